/* rtl/dqne_pkg.sv */
// shared types and constants for the dns query name extractor
// no dependencies
package dqne_pkg;

    localparam int unsigned HEADER_BYTES = 12;
    localparam int unsigned MAX_PACKET   = 512;

    localparam int unsigned POS_W   = 10;
    localparam int unsigned LABEL_W = 6;
    localparam int unsigned COUNT_W = 9;
    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned STAT_W  = 3;

    localparam logic [POS_W-1:0]   HDR_LAST_POS = POS_W'(HEADER_BYTES - 1);
    localparam logic [POS_W-1:0]   PKT_LAST_POS = POS_W'(MAX_PACKET - 1);
    localparam logic [POS_W-1:0]   PKT_END_POS  = POS_W'(MAX_PACKET);
    localparam logic [COUNT_W-1:0] COUNT_MAX    = '1;

    localparam logic [BYTE_W-1:0] PTR_MASK    = 8'hC0;
    localparam logic [BYTE_W-1:0] MAX_LABEL   = 8'd63;
    localparam logic [BYTE_W-1:0] DOT_CHAR    = 8'd46;
    localparam logic [BYTE_W-1:0] CASE_OFFSET = 8'd32;
    localparam logic [BYTE_W-1:0] UPPER_A     = 8'd65;
    localparam logic [BYTE_W-1:0] UPPER_Z     = 8'd90;

    typedef enum logic [1:0] {
        PH_HEADER = 2'd0,
        PH_LENGTH = 2'd1,
        PH_LABEL  = 2'd2,
        PH_DONE   = 2'd3
    } t_phase;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 3'd0,
        ST_SHORT = 3'd1,
        ST_LONG  = 3'd2,
        ST_TRUNC = 3'd3,
        ST_EMPTY = 3'd4
    } t_status;

    typedef struct packed {
        logic [POS_W-1:0]   pos;
        t_phase             phase;
        logic [LABEL_W-1:0] label_rem;
        logic [COUNT_W-1:0] count;
    } t_state;

    typedef struct packed {
        logic [BYTE_W-1:0]  char_out;
        logic               char_valid;
        logic               name_done;
        t_status            name_status;
        logic [COUNT_W-1:0] name_length;
    } t_result;

endpackage

/* rtl/dqne_if.sv */
// valid/ready channels for packet bytes in and name results out
// depends on dqne_pkg for field widths
interface dqne_in_if;
    logic                              valid;
    logic                              ready;
    logic [dqne_pkg::BYTE_W-1:0]       byte_value;
    logic                              last_byte;

    modport source (output valid, output byte_value, output last_byte, input ready);
    modport sink   (input valid, input byte_value, input last_byte, output ready);
endinterface

interface dqne_out_if;
    logic                              valid;
    logic                              ready;
    logic [dqne_pkg::BYTE_W-1:0]       char_out;
    logic                              char_valid;
    logic                              name_done;
    logic [dqne_pkg::STAT_W-1:0]       name_status;
    logic [dqne_pkg::COUNT_W-1:0]      name_length;

    modport source (output valid, output char_out, output char_valid, output name_done,
                    output name_status, output name_length, input ready);
    modport sink   (input valid, input char_out, input char_valid, input name_done,
                    input name_status, input name_length, output ready);
endinterface

/* rtl/dns_query_name_extract_unit.sv */
// Extracts the question name of a DNS query from its bytes, one byte per transaction,
// and gives one result per byte. A byte is taken every cycle that input ready is high; its
// result is held in the output register in the next cycle, and input ready follows the
// output side: the block takes a new byte whenever that register is empty or being read
// in the same cycle. Parser state is one small register set updated by a single
// combinational step per byte, and it returns to reset after the byte marked last.
// depends on dqne_pkg, dqne_if and dqne_step
module dns_query_name_extract_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    dqne_in_if.sink     i_in,
    dqne_out_if.source  o_out
);
    import dqne_pkg::*;

    t_state  r_state;
    t_state  n_state;
    t_result n_result;
    t_result r_result;
    logic    r_out_valid;
    logic    in_take;

    dqne_step u_step (
        .i_state  (r_state),
        .i_byte   (i_in.byte_value),
        .i_last   (i_in.last_byte),
        .o_state  (n_state),
        .o_result (n_result)
    );

    assign i_in.ready = !r_out_valid || o_out.ready;
    assign in_take    = i_in.valid && i_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= '0;
            r_state.phase <= PH_HEADER;
            r_out_valid   <= 1'b0;
        end else begin
            if (in_take) begin
                r_state <= n_state;
            end
            if (in_take) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_result <= n_result;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.char_out    = r_result.char_out;
    assign o_out.char_valid  = r_result.char_valid;
    assign o_out.name_done   = r_result.name_done;
    assign o_out.name_status = r_result.name_status;
    assign o_out.name_length = r_result.name_length;

    a_status_only_on_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_result.name_done |-> r_result.name_status == ST_OK)
        else $error("status set without name done");

    a_clear_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_take && i_in.last_byte |=> r_state.pos == '0 && r_state.phase == PH_HEADER
            && r_state.count == '0)
        else $error("parser state not cleared after last byte");

    a_pos_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.pos <= PKT_END_POS)
        else $error("byte position past packet limit");

    a_label_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.phase == PH_LABEL |-> r_state.label_rem != '0)
        else $error("inside a label with nothing remaining");

    a_done_ends_name: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_take && n_result.name_done && !i_in.last_byte |=> r_state.phase == PH_DONE)
        else $error("name done without finishing parse");
endmodule

/* rtl/dqne_step.sv */
// per-byte parse step: next parser state and result for one packet byte
// depends on dqne_pkg
module dqne_step (
    input  dqne_pkg::t_state                  i_state,
    input  logic [dqne_pkg::BYTE_W-1:0]       i_byte,
    input  logic                              i_last,
    output dqne_pkg::t_state                  o_state,
    output dqne_pkg::t_result                 o_result
);
    import dqne_pkg::*;

    always_comb begin
        t_state             s;
        t_result            r;
        logic               pkt_end;
        logic               bump;
        logic [LABEL_W-1:0] rem_dec;

        s       = i_state;
        r       = '0;
        r.name_status = ST_OK;
        bump    = 1'b0;
        pkt_end = i_last || (i_state.pos == PKT_LAST_POS);
        rem_dec = i_state.label_rem - LABEL_W'(1);

        if (i_state.pos < PKT_END_POS && i_state.phase != PH_DONE) begin
            case (i_state.phase)
                PH_HEADER: begin
                    if (i_state.pos >= HDR_LAST_POS) begin
                        s.phase = PH_LENGTH;
                        if (pkt_end) begin
                            r.name_done   = 1'b1;
                            r.name_status = ST_EMPTY;
                        end
                    end else if (pkt_end) begin
                        r.name_done   = 1'b1;
                        r.name_status = ST_SHORT;
                    end
                end
                PH_LENGTH: begin
                    if (i_byte == '0 || (i_byte & PTR_MASK) == PTR_MASK) begin
                        r.name_done   = 1'b1;
                        r.name_status = (i_state.count == '0) ? ST_EMPTY : ST_OK;
                    end else if (i_byte > MAX_LABEL) begin
                        r.name_done   = 1'b1;
                        r.name_status = ST_LONG;
                    end else if (pkt_end) begin
                        r.name_done   = 1'b1;
                        r.name_status = ST_TRUNC;
                    end else begin
                        if (i_state.count != '0) begin
                            r.char_out   = DOT_CHAR;
                            r.char_valid = 1'b1;
                            bump         = 1'b1;
                        end
                        s.label_rem = i_byte[LABEL_W-1:0];
                        s.phase     = PH_LABEL;
                    end
                end
                default: begin
                    if (pkt_end && i_state.label_rem > LABEL_W'(1)) begin
                        r.name_done   = 1'b1;
                        r.name_status = ST_TRUNC;
                    end else begin
                        r.char_out   = (i_byte inside {[UPPER_A:UPPER_Z]}) ?
                                       i_byte + CASE_OFFSET : i_byte;
                        r.char_valid = 1'b1;
                        bump         = 1'b1;
                        s.label_rem  = rem_dec;
                        if (rem_dec == '0) begin
                            s.phase = PH_LENGTH;
                        end
                        if (pkt_end) begin
                            r.name_done   = 1'b1;
                            r.name_status = (i_state.count == '0 && !bump) ? ST_EMPTY : ST_OK;
                        end
                    end
                end
            endcase
            if (bump && s.count != COUNT_MAX) begin
                s.count = s.count + COUNT_W'(1);
            end
            if (r.name_done) begin
                s.phase = PH_DONE;
            end
            s.pos = i_state.pos + POS_W'(1);
        end

        r.name_length = s.count;
        if (i_last) begin
            s = '0;
            s.phase = PH_HEADER;
        end
        o_state  = s;
        o_result = r;
    end
endmodule
